@@ hdl/rsvg_pkg.sv @@
// rsvg_pkg: shared types, constants and helpers for the ring segment vertex generator
// no dependencies
package rsvg_pkg;

   localparam int DIV_WIDTH   = 41;
   localparam int DIV_STEPS   = 8;
   localparam int DIV_REM_W   = 9;
   localparam int DIV_STATE_W = DIV_WIDTH + DIV_REM_W;
   localparam int TRIG_W      = 34;
   localparam int Z_W         = 33;
   localparam int PROD_W      = TRIG_W + 17;

   localparam logic signed [TRIG_W-1:0] CORDIC_K = 34'sh026DD3B6A;
   localparam int unsigned TOL_SCALE = 62832;
   localparam logic [15:0] ONE_Q15 = 16'h8000;

   localparam logic [31:0] ATAN_TABLE [24] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
      32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
      32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
   };

   typedef enum logic [2:0] {
      CSR_INNER_RADIUS  = 3'd0,
      CSR_OUTER_RADIUS  = 3'd1,
      CSR_START_ANGLE   = 3'd2,
      CSR_END_ANGLE     = 3'd3,
      CSR_SEGMENT_COUNT = 3'd4,
      CSR_FLIP_U        = 3'd5,
      CSR_FLIP_V        = 3'd6
   } rsvg_csr_type;

   typedef enum logic [1:0] {
      QUAD_0 = 2'd0,
      QUAD_1 = 2'd1,
      QUAD_2 = 2'd2,
      QUAD_3 = 2'd3
   } rsvg_quad_type;

   typedef struct packed {
      logic [7:0]  seg;
      logic        bad;
      logic [15:0] tex_u;
   } rsvg_tag_type;

   typedef struct packed {
      logic signed [15:0] out_x;
      logic signed [15:0] out_y;
      logic signed [15:0] in_x;
      logic signed [15:0] in_y;
      logic [15:0]        tex_u;
      logic [15:0]        tex_v_out;
      logic [15:0]        tex_v_in;
      logic [8:0]         c0;
      logic [8:0]         c1;
      logic [8:0]         c2;
      logic [8:0]         c3;
      logic               bad;
   } rsvg_pair_type;

   function automatic logic [DIV_STATE_W-1:0] div_step(input logic [DIV_STATE_W-1:0] st,
                                                       input logic [DIV_REM_W-1:0] dvs);
      logic [DIV_REM_W:0]   trial;
      logic [DIV_WIDTH-1:0] work;
      trial = {st[DIV_STATE_W-1:DIV_WIDTH], st[DIV_WIDTH-1]};
      work  = {st[DIV_WIDTH-2:0], 1'b0};
      if (trial >= {1'b0, dvs}) begin
         trial   = trial - {1'b0, dvs};
         work[0] = 1'b1;
      end
      return {trial[DIV_REM_W-1:0], work};
   endfunction

endpackage

@@ hdl/rsvg_divider.sv @@
// rsvg_divider: pipelined restoring divider, two lanes sharing one divisor
// depends on rsvg_pkg
module rsvg_divider (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  rsvg_pkg::rsvg_tag_type      in_tag,
   input  logic [rsvg_pkg::DIV_WIDTH-1:0] in_num_a,
   input  logic [rsvg_pkg::DIV_WIDTH-1:0] in_num_b,
   input  logic [8:0]                  divisor,
   output logic                        out_valid,
   output rsvg_pkg::rsvg_tag_type      out_tag,
   output logic [rsvg_pkg::DIV_WIDTH-1:0] out_quo_a,
   output logic [rsvg_pkg::DIV_WIDTH-1:0] out_quo_b
);
   import rsvg_pkg::*;

   localparam int NSTG = (DIV_WIDTH + DIV_STEPS - 1) / DIV_STEPS;

   logic [DIV_STATE_W-1:0] src_a [NSTG];
   logic [DIV_STATE_W-1:0] src_b [NSTG];
   logic                   src_v [NSTG];
   rsvg_tag_type           src_t [NSTG];
   logic [DIV_STATE_W-1:0] a_in  [NSTG];
   logic [DIV_STATE_W-1:0] b_in  [NSTG];
   logic [DIV_STATE_W-1:0] a_ff  [NSTG];
   logic [DIV_STATE_W-1:0] b_ff  [NSTG];
   logic                   v_ff  [NSTG];
   rsvg_tag_type           t_ff  [NSTG];

   assign src_a[0] = {{DIV_REM_W{1'b0}}, in_num_a};
   assign src_b[0] = {{DIV_REM_W{1'b0}}, in_num_b};
   assign src_v[0] = in_valid;
   assign src_t[0] = in_tag;

   for (genvar k = 1; k < NSTG; k++) begin : g_src
      assign src_a[k] = a_ff[k-1];
      assign src_b[k] = b_ff[k-1];
      assign src_v[k] = v_ff[k-1];
      assign src_t[k] = t_ff[k-1];
   end

   always_comb begin
      for (int k = 0; k < NSTG; k++) begin
         a_in[k] = src_a[k];
         b_in[k] = src_b[k];
         for (int j = 0; j < DIV_STEPS; j++) begin
            if (k * DIV_STEPS + j < DIV_WIDTH) begin
               a_in[k] = div_step(a_in[k], divisor);
               b_in[k] = div_step(b_in[k], divisor);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NSTG; k++) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= src_v[k];
         end
         if (en) begin
            a_ff[k] <= a_in[k];
            b_ff[k] <= b_in[k];
            t_ff[k] <= src_t[k];
         end
      end
   end

   assign out_valid = v_ff[NSTG-1];
   assign out_tag   = t_ff[NSTG-1];
   assign out_quo_a = a_ff[NSTG-1][DIV_WIDTH-1:0];
   assign out_quo_b = b_ff[NSTG-1][DIV_WIDTH-1:0];

endmodule

@@ hdl/rsvg_cordic.sv @@
// rsvg_cordic: pipelined rotation-mode cordic with quadrant folding
// depends on rsvg_pkg
module rsvg_cordic #(
   parameter int STAGES = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           en,
   input  logic                           in_valid,
   input  rsvg_pkg::rsvg_tag_type         in_tag,
   input  logic [31:0]                    in_phase,
   output logic                           out_valid,
   output rsvg_pkg::rsvg_tag_type         out_tag,
   output logic signed [rsvg_pkg::TRIG_W-1:0] out_cos,
   output logic signed [rsvg_pkg::TRIG_W-1:0] out_sin
);
   import rsvg_pkg::*;

   localparam int PER  = 2;
   localparam int NSTG = (STAGES + PER - 1) / PER;

   logic signed [TRIG_W-1:0] src_x [NSTG];
   logic signed [TRIG_W-1:0] src_y [NSTG];
   logic signed [Z_W-1:0]    src_z [NSTG];
   rsvg_quad_type            src_q [NSTG];
   logic                     src_v [NSTG];
   rsvg_tag_type             src_t [NSTG];
   logic signed [TRIG_W-1:0] x_in  [NSTG];
   logic signed [TRIG_W-1:0] y_in  [NSTG];
   logic signed [Z_W-1:0]    z_in  [NSTG];
   logic signed [TRIG_W-1:0] x_ff  [NSTG];
   logic signed [TRIG_W-1:0] y_ff  [NSTG];
   logic signed [Z_W-1:0]    z_ff  [NSTG];
   rsvg_quad_type            q_ff  [NSTG];
   logic                     v_ff  [NSTG];
   rsvg_tag_type             t_ff  [NSTG];
   logic signed [TRIG_W-1:0] cos_in, sin_in, cos_ff, sin_ff;
   logic                     fv_ff;
   rsvg_tag_type             ft_ff;

   assign src_x[0] = CORDIC_K;
   assign src_y[0] = '0;
   assign src_z[0] = $signed({3'b000, in_phase[29:0]});
   assign src_q[0] = rsvg_quad_type'(in_phase[31:30]);
   assign src_v[0] = in_valid;
   assign src_t[0] = in_tag;

   for (genvar k = 1; k < NSTG; k++) begin : g_src
      assign src_x[k] = x_ff[k-1];
      assign src_y[k] = y_ff[k-1];
      assign src_z[k] = z_ff[k-1];
      assign src_q[k] = q_ff[k-1];
      assign src_v[k] = v_ff[k-1];
      assign src_t[k] = t_ff[k-1];
   end

   always_comb begin
      logic signed [TRIG_W-1:0] dx, dy;
      logic signed [Z_W-1:0]    at;
      for (int k = 0; k < NSTG; k++) begin
         x_in[k] = src_x[k];
         y_in[k] = src_y[k];
         z_in[k] = src_z[k];
         for (int j = 0; j < PER; j++) begin
            if (k * PER + j < STAGES) begin
               dx = y_in[k] >>> (k * PER + j);
               dy = x_in[k] >>> (k * PER + j);
               at = $signed({1'b0, ATAN_TABLE[k * PER + j]});
               if (!z_in[k][Z_W-1]) begin
                  x_in[k] = x_in[k] - dx;
                  y_in[k] = y_in[k] + dy;
                  z_in[k] = z_in[k] - at;
               end else begin
                  x_in[k] = x_in[k] + dx;
                  y_in[k] = y_in[k] - dy;
                  z_in[k] = z_in[k] + at;
               end
            end
         end
      end
   end

   always_comb begin
      case (q_ff[NSTG-1])
         QUAD_0: begin
            cos_in = x_ff[NSTG-1];
            sin_in = y_ff[NSTG-1];
         end
         QUAD_1: begin
            cos_in = -y_ff[NSTG-1];
            sin_in = x_ff[NSTG-1];
         end
         QUAD_2: begin
            cos_in = -x_ff[NSTG-1];
            sin_in = -y_ff[NSTG-1];
         end
         default: begin
            cos_in = y_ff[NSTG-1];
            sin_in = -x_ff[NSTG-1];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NSTG; k++) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= src_v[k];
         end
         if (en) begin
            x_ff[k] <= x_in[k];
            y_ff[k] <= y_in[k];
            z_ff[k] <= z_in[k];
            q_ff[k] <= src_q[k];
            t_ff[k] <= src_t[k];
         end
      end
      if (reset) begin
         fv_ff <= 1'b0;
      end else if (en) begin
         fv_ff <= v_ff[NSTG-1];
      end
      if (en) begin
         cos_ff <= cos_in;
         sin_ff <= sin_in;
         ft_ff  <= t_ff[NSTG-1];
      end
   end

   assign out_valid = fv_ff;
   assign out_tag   = ft_ff;
   assign out_cos   = cos_ff;
   assign out_sin   = sin_ff;

endmodule

@@ hdl/rsvg_scale.sv @@
// rsvg_scale: radius multiply, round and saturate, corner indices; holds the result pair
// depends on rsvg_pkg
module rsvg_scale (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           en,
   input  logic                           in_valid,
   input  rsvg_pkg::rsvg_tag_type         in_tag,
   input  logic signed [rsvg_pkg::TRIG_W-1:0] in_cos,
   input  logic signed [rsvg_pkg::TRIG_W-1:0] in_sin,
   input  logic [15:0]                    r_out,
   input  logic [15:0]                    r_in,
   input  logic [8:0]                     count,
   input  logic                           flip_v,
   output logic                           out_valid,
   output rsvg_pkg::rsvg_pair_type        out_pair
);
   import rsvg_pkg::*;

   localparam int Q_W = PROD_W - 30;
   localparam logic signed [Q_W-1:0] SAT_HI = Q_W'(32767);
   localparam logic signed [Q_W-1:0] SAT_LO = -Q_W'(32768);
   localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(64'd1 << 29);

   function automatic logic signed [15:0] round_sat(input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W-1:0] r;
      logic signed [Q_W-1:0]    q;
      r = p + ROUND_HALF;
      q = r[PROD_W-1:30];
      if (q > SAT_HI) begin
         return 16'sh7FFF;
      end else if (q < SAT_LO) begin
         return 16'sh8000;
      end
      return q[15:0];
   endfunction

   logic signed [PROD_W-1:0] ox_ff, oy_ff, ix_ff, iy_ff;
   logic                     a_valid_ff;
   rsvg_tag_type             a_tag_ff;
   logic                     pair_valid_ff;
   rsvg_pair_type            pair_ff, pair_in;
   logic [10:0]              two_i, two_n, t2, t3;

   always_comb begin
      two_i = {2'b00, a_tag_ff.seg, 1'b0};
      two_n = {1'b0, count, 1'b0};
      t2    = two_i + 11'd2;
      t3    = two_i + 11'd3;
      if (t2 >= two_n) begin
         t2 = t2 - two_n;
      end
      if (t3 >= two_n) begin
         t3 = t3 - two_n;
      end
      pair_in.out_x     = round_sat(ox_ff);
      pair_in.out_y     = round_sat(oy_ff);
      pair_in.in_x      = round_sat(ix_ff);
      pair_in.in_y      = round_sat(iy_ff);
      pair_in.tex_u     = a_tag_ff.tex_u;
      pair_in.tex_v_out = flip_v ? ONE_Q15 : 16'd0;
      pair_in.tex_v_in  = flip_v ? 16'd0 : ONE_Q15;
      pair_in.c0        = two_i[8:0];
      pair_in.c1        = two_i[8:0] + 9'd1;
      pair_in.c2        = t2[8:0];
      pair_in.c3        = t3[8:0];
      pair_in.bad       = a_tag_ff.bad;
      if (a_tag_ff.bad) begin
         pair_in     = '0;
         pair_in.bad = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff    <= 1'b0;
         pair_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff    <= in_valid;
         pair_valid_ff <= a_valid_ff;
      end
      if (en) begin
         ox_ff    <= in_cos * $signed({1'b0, r_out});
         oy_ff    <= in_sin * $signed({1'b0, r_out});
         ix_ff    <= in_cos * $signed({1'b0, r_in});
         iy_ff    <= in_sin * $signed({1'b0, r_in});
         a_tag_ff <= in_tag;
         pair_ff  <= pair_in;
      end
   end

   assign out_valid = pair_valid_ff;
   assign out_pair  = pair_ff;

endmodule

@@ hdl/ring_segment_vertex_generator.sv @@
// ring_segment_vertex_generator: top level, csr registers, entry stage and result sequencing
// depends on rsvg_pkg, rsvg_divider, rsvg_cordic, rsvg_scale
// pipeline registers from accepted segment to outer result: entry 1, divider 6,
// cordic ceil(CORDIC_STAGES/2)+1, scale 2
// segments overlap in the pipeline, which holds until both results of a pair are taken
// reset: synchronous, clears all valid bits; csr registers return to defaults (count 32)
module ring_segment_vertex_generator #(
   parameter int MAX_SEGMENTS  = 256,
   parameter int ANGLE_BITS    = 16,
   parameter int CORDIC_STAGES = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_segment,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_pos_x,
   output logic signed [15:0] rsp_pos_y,
   output logic [15:0]        rsp_tex_u,
   output logic [15:0]        rsp_tex_v,
   output logic [8:0]         rsp_corner_a,
   output logic [8:0]         rsp_corner_b,
   output logic [8:0]         rsp_corner_c,
   output logic               rsp_is_inner,
   output logic               rsp_last,
   output logic               rsp_bad_segment,
   input  logic               csr_wr_en,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_wr_data
);
   import rsvg_pkg::*;

   localparam int AW = ANGLE_BITS;
   localparam int TW = AW + 16;
   localparam logic [AW:0] TURN = (AW+1)'(1) << AW;

   logic [15:0] inner_radius_ff, outer_radius_ff, start_angle_ff, end_angle_ff;
   logic [8:0]  segment_count_ff;
   logic        flip_u_ff, flip_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         inner_radius_ff  <= '0;
         outer_radius_ff  <= '0;
         start_angle_ff   <= '0;
         end_angle_ff     <= '0;
         segment_count_ff <= 9'd32;
         flip_u_ff        <= 1'b0;
         flip_v_ff        <= 1'b0;
      end else if (csr_wr_en) begin
         case (rsvg_csr_type'(csr_index))
            CSR_INNER_RADIUS:  inner_radius_ff  <= csr_wr_data;
            CSR_OUTER_RADIUS:  outer_radius_ff  <= csr_wr_data;
            CSR_START_ANGLE:   start_angle_ff   <= csr_wr_data;
            CSR_END_ANGLE:     end_angle_ff     <= csr_wr_data;
            CSR_SEGMENT_COUNT: segment_count_ff <= csr_wr_data[8:0];
            CSR_FLIP_U:        flip_u_ff        <= csr_wr_data[0];
            CSR_FLIP_V:        flip_v_ff        <= csr_wr_data[0];
            default: ;
         endcase
      end
   end

   // static arc setup from csr registers
   logic [15:0]   ang_lo, ang_hi, r_in, r_out;
   logic [AW-1:0] s_ang, e_ang, d_ang;
   logic [TW-1:0] d_scaled;
   logic          near_full;
   logic [AW:0]   span;
   logic [8:0]    n_eff;

   always_comb begin
      ang_lo   = (start_angle_ff > end_angle_ff) ? end_angle_ff : start_angle_ff;
      ang_hi   = (start_angle_ff > end_angle_ff) ? start_angle_ff : end_angle_ff;
      s_ang    = AW'(ang_lo);
      e_ang    = AW'(ang_hi);
      d_ang    = (e_ang >= s_ang) ? e_ang - s_ang : s_ang - e_ang;
      d_scaled = TW'(d_ang) * TW'(TOL_SCALE);
      near_full = d_scaled < TW'(TURN);
      span     = near_full ? TURN : {1'b0, AW'(e_ang - s_ang)};
      if (segment_count_ff == 9'd0) begin
         n_eff = 9'd1;
      end else if (32'(segment_count_ff) > 32'(MAX_SEGMENTS)) begin
         n_eff = 9'(MAX_SEGMENTS);
      end else begin
         n_eff = segment_count_ff;
      end
      r_in  = (inner_radius_ff < outer_radius_ff) ? inner_radius_ff : outer_radius_ff;
      r_out = (inner_radius_ff < outer_radius_ff) ? outer_radius_ff : inner_radius_ff;
   end

   // pipeline advance and result sequencing
   logic          en, sel_ff, pair_valid;
   rsvg_pair_type pair;

   assign en        = !pair_valid || (rsp_ready && sel_ff);
   assign req_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff <= 1'b0;
      end else if (rsp_valid && rsp_ready) begin
         sel_ff <= !sel_ff;
      end
   end

   // entry stage
   logic                 e_valid_ff;
   rsvg_tag_type         e_tag_ff, e_tag_in;
   logic [DIV_WIDTH-1:0] e_num_a_ff, e_num_b_ff;
   logic [AW+8:0]        span_seg;

   always_comb begin
      span_seg       = (AW+9)'(span) * (AW+9)'(req_segment);
      e_tag_in.seg   = req_segment;
      e_tag_in.bad   = {1'b0, req_segment} >= n_eff;
      e_tag_in.tex_u = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else if (en) begin
         e_valid_ff <= req_valid;
      end
      if (en) begin
         e_tag_ff   <= e_tag_in;
         e_num_a_ff <= {span_seg, (32-AW)'(0)};
         e_num_b_ff <= DIV_WIDTH'({req_segment, 15'd0});
      end
   end

   logic                 d_valid;
   rsvg_tag_type         d_tag, c_tag_in;
   logic [DIV_WIDTH-1:0] quo_a, quo_b;
   logic [31:0]          phase;

   rsvg_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (e_valid_ff),
      .in_tag    (e_tag_ff),
      .in_num_a  (e_num_a_ff),
      .in_num_b  (e_num_b_ff),
      .divisor   (n_eff),
      .out_valid (d_valid),
      .out_tag   (d_tag),
      .out_quo_a (quo_a),
      .out_quo_b (quo_b)
   );

   always_comb begin
      phase          = {s_ang, (32-AW)'(0)} + quo_a[31:0];
      c_tag_in       = d_tag;
      c_tag_in.tex_u = flip_u_ff ? ONE_Q15 - quo_b[15:0] : quo_b[15:0];
   end

   logic                     c_valid;
   rsvg_tag_type             c_tag;
   logic signed [TRIG_W-1:0] c_cos, c_sin;

   rsvg_cordic #(
      .STAGES (CORDIC_STAGES)
   ) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (d_valid),
      .in_tag    (c_tag_in),
      .in_phase  (phase),
      .out_valid (c_valid),
      .out_tag   (c_tag),
      .out_cos   (c_cos),
      .out_sin   (c_sin)
   );

   rsvg_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (c_valid),
      .in_tag    (c_tag),
      .in_cos    (c_cos),
      .in_sin    (c_sin),
      .r_out     (r_out),
      .r_in      (r_in),
      .count     (n_eff),
      .flip_v    (flip_v_ff),
      .out_valid (pair_valid),
      .out_pair  (pair)
   );

   // outer transaction first, then inner
   assign rsp_valid       = pair_valid;
   assign rsp_pos_x       = sel_ff ? pair.in_x : pair.out_x;
   assign rsp_pos_y       = sel_ff ? pair.in_y : pair.out_y;
   assign rsp_tex_u       = pair.tex_u;
   assign rsp_tex_v       = sel_ff ? pair.tex_v_in : pair.tex_v_out;
   assign rsp_corner_a    = sel_ff ? pair.c2 : pair.c0;
   assign rsp_corner_b    = pair.c1;
   assign rsp_corner_c    = sel_ff ? pair.c3 : pair.c2;
   assign rsp_is_inner    = sel_ff;
   assign rsp_last        = sel_ff;
   assign rsp_bad_segment = pair.bad;

endmodule

@@ hdl/rsvg_checker.sv @@
// rsvg_checker: port-level assertions for ring_segment_vertex_generator, with bind
// depends on ring_segment_vertex_generator ports only
module rsvg_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [15:0] rsp_pos_x,
   input logic signed [15:0] rsp_pos_y,
   input logic [15:0]        rsp_tex_u,
   input logic [15:0]        rsp_tex_v,
   input logic [8:0]         rsp_corner_a,
   input logic [8:0]         rsp_corner_b,
   input logic [8:0]         rsp_corner_c,
   input logic               rsp_is_inner,
   input logic               rsp_last,
   input logic               rsp_bad_segment
);

   // outer transaction is always followed by its inner partner
   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_valid && rsp_last)
      else $error("inner result missing after outer");

   a_last_inner: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_last == rsp_is_inner)
      else $error("last and is_inner disagree");

   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_segment |-> rsp_pos_x == 16'sd0 && rsp_pos_y == 16'sd0
         && rsp_tex_u == 16'd0 && rsp_tex_v == 16'd0 && rsp_corner_a == 9'd0
         && rsp_corner_b == 9'd0 && rsp_corner_c == 9'd0)
      else $error("bad segment with nonzero payload");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pos_x) && $stable(rsp_pos_y)
         && $stable(rsp_tex_v) && $stable(rsp_last))
      else $error("stalled result changed");

endmodule

bind ring_segment_vertex_generator rsvg_checker u_rsvg_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_pos_x       (rsp_pos_x),
   .rsp_pos_y       (rsp_pos_y),
   .rsp_tex_u       (rsp_tex_u),
   .rsp_tex_v       (rsp_tex_v),
   .rsp_corner_a    (rsp_corner_a),
   .rsp_corner_b    (rsp_corner_b),
   .rsp_corner_c    (rsp_corner_c),
   .rsp_is_inner    (rsp_is_inner),
   .rsp_last        (rsp_last),
   .rsp_bad_segment (rsp_bad_segment)
);

@@ verif/testbench.sv @@
// testbench: self-checking bench for ring_segment_vertex_generator
// drives segment transactions, predicts both vertex results per segment and checks them
// depends on rsvg_pkg and the ring_segment_vertex_generator rtl
module testbench;
   import rsvg_pkg::*;

   localparam int LATENCY = 18;
   localparam longint CYCLE_LIMIT = 2000000;

   typedef struct {
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic [15:0]        tex_u;
      logic [15:0]        tex_v;
      logic [8:0]         corner_a;
      logic [8:0]         corner_b;
      logic [8:0]         corner_c;
      logic               is_inner;
      logic               last;
      logic               bad_segment;
   } vertex_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [7:0] req_segment = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [15:0] rsp_pos_x, rsp_pos_y;
   logic [15:0] rsp_tex_u, rsp_tex_v;
   logic [8:0] rsp_corner_a, rsp_corner_b, rsp_corner_c;
   logic rsp_is_inner, rsp_last, rsp_bad_segment;
   logic csr_wr_en = 1'b0;
   logic [2:0] csr_index = '0;
   logic [15:0] csr_wr_data = '0;

   logic [15:0] cfg_inner, cfg_outer, cfg_start, cfg_end;
   logic [8:0]  cfg_count;
   logic        cfg_flip_u, cfg_flip_v;

   logic [7:0]  segment_queue[$];
   vertex_type  expected_vertices[$];
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          hold_off_cycles = 0;
   int          error_count = 0;
   int          vertex_count = 0;
   longint      cycle_count = 0;

   ring_segment_vertex_generator DUT (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   function automatic longint floor_shr(longint v, int sh);
      return v >>> sh;
   endfunction

   function automatic logic signed [15:0] scaled_position(longint trig, logic [15:0] radius);
      longint p;
      p = floor_shr(trig * longint'(radius) + (longint'(1) << 29), 30);
      if (p > 32767) p = 32767;
      if (p < -32768) p = -32768;
      return p[15:0];
   endfunction

   task automatic predict_vertices(input logic [7:0] seg);
      longint unsigned n, s, e, d, span, phase, t;
      longint x, y, z, dx, dy, cs, sn;
      logic [15:0] r_in, r_out, u;
      logic [1:0] quad;
      longint unsigned two_n;
      vertex_type outer_v, inner_v;
      n = cfg_count;
      if (n == 0) n = 1;
      if (n > 256) n = 256;
      outer_v = '{default: '0};
      inner_v = '{default: '0};
      inner_v.is_inner = 1'b1;
      inner_v.last = 1'b1;
      if (seg >= n) begin
         outer_v.bad_segment = 1'b1;
         inner_v.bad_segment = 1'b1;
      end else begin
         s = cfg_start;
         e = cfg_end;
         if (s > e) begin
            t = s; s = e; e = t;
         end
         d = (e >= s) ? e - s : s - e;
         if (d * TOL_SCALE < 65536) span = 65536;
         else span = e - s;
         phase = ((s << 16) + (span << 16) * seg / n) & 64'hFFFF_FFFF;
         quad = phase[31:30];
         z = longint'(phase & 64'h3FFF_FFFF);
         x = CORDIC_K;
         y = 0;
         for (int i = 0; i < 16; i++) begin
            dx = floor_shr(y, i);
            dy = floor_shr(x, i);
            if (z >= 0) begin
               x -= dx; y += dy; z -= longint'(ATAN_TABLE[i]);
            end else begin
               x += dx; y -= dy; z += longint'(ATAN_TABLE[i]);
            end
         end
         case (rsvg_quad_type'(quad))
            QUAD_0: begin cs = x; sn = y; end
            QUAD_1: begin cs = -y; sn = x; end
            QUAD_2: begin cs = -x; sn = -y; end
            default: begin cs = y; sn = -x; end
         endcase
         r_in = (cfg_inner < cfg_outer) ? cfg_inner : cfg_outer;
         r_out = (cfg_inner < cfg_outer) ? cfg_outer : cfg_inner;
         u = 16'((longint'(seg) * 32768) / n);
         if (cfg_flip_u) u = ONE_Q15 - u;
         two_n = 2 * n;
         outer_v.pos_x = scaled_position(cs, r_out);
         outer_v.pos_y = scaled_position(sn, r_out);
         outer_v.tex_u = u;
         outer_v.tex_v = cfg_flip_v ? ONE_Q15 : 16'd0;
         outer_v.corner_a = 9'(2 * seg);
         outer_v.corner_b = 9'(2 * seg + 1);
         outer_v.corner_c = 9'((2 * seg + 2) % two_n);
         inner_v.pos_x = scaled_position(cs, r_in);
         inner_v.pos_y = scaled_position(sn, r_in);
         inner_v.tex_u = u;
         inner_v.tex_v = cfg_flip_v ? 16'd0 : ONE_Q15;
         inner_v.corner_a = 9'((2 * seg + 2) % two_n);
         inner_v.corner_b = 9'(2 * seg + 1);
         inner_v.corner_c = 9'((2 * seg + 3) % two_n);
      end
      expected_vertices.push_back(outer_v);
      expected_vertices.push_back(inner_v);
   endtask

   // driver
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            predict_vertices(req_segment);
            void'(segment_queue.pop_front());
         end
         if (!(req_valid && !req_ready)) begin
            if (segment_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_segment <= segment_queue[0];
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      vertex_type exp_v;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            vertex_count <= vertex_count + 1;
            if (expected_vertices.size() == 0) begin
               $error("unexpected vertex transaction");
               error_count++;
            end else begin
               exp_v = expected_vertices.pop_front();
               if (rsp_pos_x !== exp_v.pos_x) begin
                  $error("pos_x exp %0d got %0d", exp_v.pos_x, rsp_pos_x); error_count++;
               end
               if (rsp_pos_y !== exp_v.pos_y) begin
                  $error("pos_y exp %0d got %0d", exp_v.pos_y, rsp_pos_y); error_count++;
               end
               if (rsp_tex_u !== exp_v.tex_u) begin
                  $error("tex_u exp %0d got %0d", exp_v.tex_u, rsp_tex_u); error_count++;
               end
               if (rsp_tex_v !== exp_v.tex_v) begin
                  $error("tex_v exp %0d got %0d", exp_v.tex_v, rsp_tex_v); error_count++;
               end
               if (rsp_corner_a !== exp_v.corner_a) begin
                  $error("corner_a exp %0d got %0d", exp_v.corner_a, rsp_corner_a);
                  error_count++;
               end
               if (rsp_corner_b !== exp_v.corner_b) begin
                  $error("corner_b exp %0d got %0d", exp_v.corner_b, rsp_corner_b);
                  error_count++;
               end
               if (rsp_corner_c !== exp_v.corner_c) begin
                  $error("corner_c exp %0d got %0d", exp_v.corner_c, rsp_corner_c);
                  error_count++;
               end
               if (rsp_is_inner !== exp_v.is_inner) begin
                  $error("is_inner exp %0d got %0d", exp_v.is_inner, rsp_is_inner);
                  error_count++;
               end
               if (rsp_last !== exp_v.last) begin
                  $error("last exp %0d got %0d", exp_v.last, rsp_last); error_count++;
               end
               if (rsp_bad_segment !== exp_v.bad_segment) begin
                  $error("bad_segment exp %0d got %0d", exp_v.bad_segment, rsp_bad_segment);
                  error_count++;
               end
            end
         end
         if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   task automatic write_register(input rsvg_csr_type idx, input logic [15:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= value;
      case (idx)
         CSR_INNER_RADIUS:  cfg_inner = value;
         CSR_OUTER_RADIUS:  cfg_outer = value;
         CSR_START_ANGLE:   cfg_start = value;
         CSR_END_ANGLE:     cfg_end = value;
         CSR_SEGMENT_COUNT: cfg_count = value[8:0];
         CSR_FLIP_U:        cfg_flip_u = value[0];
         default:           cfg_flip_v = value[0];
      endcase
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic drain_results();
      while (segment_queue.size() > 0 || req_valid || expected_vertices.size() > 0)
         @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic load_setting(input logic [15:0] r0, r1, a0, a1, input logic [8:0] cnt,
                               input logic fu, fv);
      drain_results();
      write_register(CSR_INNER_RADIUS, r0);
      write_register(CSR_OUTER_RADIUS, r1);
      write_register(CSR_START_ANGLE, a0);
      write_register(CSR_END_ANGLE, a1);
      write_register(CSR_SEGMENT_COUNT, {7'd0, cnt});
      write_register(CSR_FLIP_U, {15'd0, fu});
      write_register(CSR_FLIP_V, {15'd0, fv});
   endtask

   task automatic random_setting();
      logic [8:0] cnt;
      logic [15:0] a0;
      case ($urandom_range(3))
         0: cnt = 9'($urandom_range(1, 8));
         1: cnt = 9'($urandom_range(9, 256));
         2: cnt = 9'($urandom_range(0, 511));
         default: cnt = 9'd256;
      endcase
      a0 = 16'($urandom);
      load_setting(16'($urandom), 16'($urandom), a0,
                   ($urandom_range(3) == 0) ? a0 + 16'($urandom_range(0, 2)) : 16'($urandom),
                   cnt, 1'($urandom), 1'($urandom));
   endtask

   function automatic logic [7:0] pick_segment();
      int n;
      n = (cfg_count == 0) ? 1 : (cfg_count > 256 ? 256 : cfg_count);
      if ($urandom_range(9) == 0) return 8'($urandom);
      return 8'($urandom_range(0, n - 1));
   endfunction

   initial begin
      cfg_inner = 0; cfg_outer = 0; cfg_start = 0; cfg_end = 0;
      cfg_count = 9'd32; cfg_flip_u = 0; cfg_flip_v = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: defaults, then extremes
      segment_queue.push_back(8'd0);
      segment_queue.push_back(8'd31);
      segment_queue.push_back(8'd32);
      load_setting(16'hFFFF, 16'h0100, 16'h0000, 16'h0000, 9'd256, 1'b0, 1'b0);
      foreach (segment_queue[i]) ;
      segment_queue.push_back(8'd0);
      segment_queue.push_back(8'd64);
      segment_queue.push_back(8'd128);
      segment_queue.push_back(8'd192);
      segment_queue.push_back(8'd255);
      load_setting(16'h0080, 16'hFFFF, 16'hFFFF, 16'h4000, 9'd3, 1'b1, 1'b1);
      for (int i = 0; i < 5; i++) segment_queue.push_back(8'(i));
      load_setting(16'h1234, 16'h0000, 16'h1000, 16'h1001, 9'd0, 1'b0, 1'b1);
      segment_queue.push_back(8'd0);
      segment_queue.push_back(8'd1);
      load_setting(16'h0200, 16'h0300, 16'hC000, 16'h2000, 9'd511, 1'b1, 1'b0);
      segment_queue.push_back(8'd255);
      segment_queue.push_back(8'd100);
      segment_queue.push_back(8'd170);

      // random phases under the three idle mixes
      for (int phase = 0; phase < 18; phase++) begin
         random_setting();
         if (phase < 6) begin
            send_idle_pct = 11; recv_idle_pct = 86;
         end else if (phase < 12) begin
            send_idle_pct = 86; recv_idle_pct = 11;
         end else begin
            send_idle_pct = 0; recv_idle_pct = 0;
         end
         if (phase == 14) hold_off_cycles = 300;
         for (int i = 0; i < 75; i++) segment_queue.push_back(pick_segment());
         if (phase == 8) begin
            while (segment_queue.size() > 30) @(posedge clock);
            // no new segments are queued until no request is pending and no result is outstanding
            while (req_valid || expected_vertices.size() > 0) @(posedge clock);
            for (int i = 0; i < 30; i++) segment_queue.push_back(pick_segment());
         end
      end
      drain_results();
      $display("covered %0d vertex transactions over 23 register settings", vertex_count);
      $display("included bad segments, count clamping, wrapped and full-circle arcs, flips");
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule

@@ files.f @@
hdl/rsvg_pkg.sv
hdl/rsvg_divider.sv
hdl/rsvg_cordic.sv
hdl/rsvg_scale.sv
hdl/ring_segment_vertex_generator.sv
hdl/rsvg_checker.sv
verif/testbench.sv
